@@ sv/swm_pkg.sv @@
`timescale 1ns / 1ps
package swm_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int              WIN_LEN_W   = 7;
  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RST = WIN_LEN_W'(3);

endpackage

@@ sv/swm_if.sv @@
`timescale 1ns / 1ps
interface swm_in_if import swm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_new;

  modport source (output valid, output sample, output start_new, input ready);
  modport sink   (input valid, input sample, input start_new, output ready);
endinterface

interface swm_out_if import swm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

interface swm_cfg_if import swm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [WIN_LEN_W-1:0] window_len;

  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface

@@ sv/swm_cell.sv @@
`timescale 1ns / 1ps
module swm_cell import swm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] prev_i,
  output logic signed [SAMPLE_BITS-1:0] pm_o
);

  // pm = max of the newest samples up to this cell's age
  logic signed [SAMPLE_BITS-1:0] pm_r;
  logic signed [SAMPLE_BITS-1:0] pm_nxt;

  assign pm_nxt = (prev_i > sample_i) ? prev_i : sample_i;

  always_ff @(posedge clk) begin
    if (en) begin
      pm_r <= pm_nxt;
    end
  end

  assign pm_o = pm_r;

endmodule

@@ sv/sliding_window_max_unit.sv @@
`timescale 1ns / 1ps
// Running maximum over the last window_len signed samples.
// in_ch  : sample plus start_new; start_new begins a new sequence.
// out_ch : window_max, one item per input once window_len samples of the
//          current sequence have arrived, none before.
// cfg_ch : window_len (0 acts as 1, values above WINDOW_MAX act as
//          WINDOW_MAX); always ready, write only while the block is idle.
// A row of WINDOW_MAX cells holds prefix maxima of the newest samples and
// shifts by one per accepted item; a live count tracks how many of them are
// still in the window. An accepted input is registered in the cells and the
// select stage, then in the output register. Throughput is one item per
// cycle while out_ch accepts results, with one select stage after the cells.
// Reset empties the window, clears the sample count and sets window_len
// to 3. When out_ch stalls, one result waits in the output register and
// one more in the select stage; then in_ch.ready drops until space frees.
module sliding_window_max_unit import swm_pkg::*; #(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  swm_in_if.sink     in_ch,
  swm_out_if.source  out_ch,
  swm_cfg_if.sink    cfg_ch
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int KW    = (CNT_W > WIN_LEN_W) ? CNT_W : WIN_LEN_W;

  logic [WIN_LEN_W-1:0] win_len_r;
  logic [CNT_W-1:0]     live_r, live_nxt;
  logic [CNT_W-1:0]     filled_r, filled_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     sel_r;
  logic                 out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_data_r;

  logic signed [SAMPLE_BITS-1:0] pm [WINDOW_MAX];

  logic [KW-1:0]    k_ext;
  logic [CNT_W-1:0] k_eff;
  logic [CNT_W-1:0] live_base, live_keep, filled_base;
  logic             out_free, accept, has_result;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    k_ext = KW'(win_len_r);
    if (k_ext == '0) begin
      k_ext = KW'(1);
    end else if (k_ext > KW'(WINDOW_MAX)) begin
      k_ext = KW'(WINDOW_MAX);
    end
    k_eff = k_ext[CNT_W-1:0];
  end

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !pend_r || out_free;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    live_base   = in_ch.start_new ? '0 : live_r;
    filled_base = in_ch.start_new ? '0 : filled_r;
    // entries aged k or more leave the window
    live_keep   = (live_base > (k_eff - CNT_W'(1))) ? (k_eff - CNT_W'(1)) : live_base;
    live_nxt    = live_keep + CNT_W'(1);
    filled_nxt  = (filled_base < CNT_W'(WINDOW_MAX)) ? filled_base + CNT_W'(1)
                                                     : filled_base;
    has_result  = (filled_nxt >= k_eff);
    if (accept) begin
      pend_nxt = has_result;
    end else if (out_free) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        swm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
          .clk      (clk),
          .en       (accept),
          .sample_i (in_ch.sample),
          .prev_i   (in_ch.sample),
          .pm_o     (pm[gi])
        );
      end else begin : g_body
        swm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
          .clk      (clk),
          .en       (accept),
          .sample_i (in_ch.sample),
          .prev_i   (pm[gi-1]),
          .pm_o     (pm[gi])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= WIN_LEN_RST;
      live_r      <= '0;
      filled_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        win_len_r <= cfg_ch.window_len;
      end
      if (accept) begin
        live_r   <= live_nxt;
        filled_r <= filled_nxt;
      end
      pend_r <= pend_nxt;
      if (out_free) begin
        out_valid_r <= pend_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sel_r <= IDX_W'(live_nxt - CNT_W'(1));
    end
    if (out_free && pend_r) begin
      out_data_r <= pm[sel_r];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.window_max = out_data_r;

endmodule
